// ----- design/ttlc_pkg.sv -----
// package for the triangle transform and light cull block
// shared widths, constants and the item and result types; depends on nothing

package ttlc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_DEPTH    = 52;
    localparam int MODEL_BASE    = 0;
    localparam int VM_BASE       = 16;
    localparam int PROJ_BASE     = 32;
    localparam int LIGHT_BASE    = 48;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_VERTEX = 1'b1;

    typedef struct packed {
        logic               op;
        logic [5:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] norm_x;
        logic signed [31:0] norm_y;
        logic signed [31:0] norm_z;
    } t_item;

    typedef struct packed {
        logic signed [31:0] ndc_x;
        logic signed [31:0] ndc_y;
        logic signed [31:0] clip_z;
        logic signed [31:0] clip_w;
        logic [30:0]        light_level;
        logic               back_facing;
        logic               last_vertex;
    } t_result;

    // transformed vertex handed from the front part to the back part
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
        logic signed [31:0] lt;
        logic               last;
    } t_vert;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

// ----- design/ttlc_if.sv -----
// valid/ready channel interface carrying one payload type
// the payload type is a parameter; depends on nothing

interface ttlc_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/ttlc_front.sv -----
// front part: coefficient store and the vertex transform sequencer
// one shared multiplier walks the 52 products of each vertex; depends on ttlc_pkg

module ttlc_front #(
    parameter int FRAC_BITS = ttlc_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ttlc_pkg::t_item      i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ttlc_pkg::t_vert      o_vert
);
    import ttlc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;
    localparam logic [1:0] S_TAIL = 2'd3;

    // phases: 0 model (16), 1 light (4), 2 view-model (16), 3 projection (16)
    logic [1:0]  r_state;
    logic [1:0]  r_phase;
    logic [1:0]  r_row, r_col;
    logic [1:0]  r_vcnt;
    logic signed [31:0] r_coef [COEF_DEPTH];
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_nrm [3];
    logic signed [31:0] r_n4 [4];
    logic signed [31:0] r_e [4];
    logic signed [31:0] r_c [4];
    logic signed [31:0] r_lt;
    logic signed [65:0] r_acc;
    logic signed [31:0] r_ca, r_cb;
    logic               r_pv;
    logic [1:0]         r_prow;
    logic [1:0]         r_pphase;
    logic               r_plast;
    logic signed [31:0] r_bias;

    logic [5:0]         coef_addr;
    logic signed [31:0] operand;
    logic signed [63:0] prod;
    logic signed [65:0] acc_sum;
    logic signed [31:0] floor_lt;
    logic               last_term;

    assign floor_lt = 32'(((64'sd1 <<< (FRAC_BITS + 1)) + 64'sd5) / 64'sd10);

    always_comb begin
        unique case (r_phase)
            2'd0: coef_addr = 6'(MODEL_BASE) + {2'b0, r_row, r_col};
            2'd1: coef_addr = 6'(LIGHT_BASE) + {4'b0, r_col};
            2'd2: coef_addr = 6'(VM_BASE) + {2'b0, r_row, r_col};
            default: coef_addr = 6'(PROJ_BASE) + {2'b0, r_row, r_col};
        endcase
        unique case (r_phase)
            2'd0: operand = (r_col == 2'd3) ? 32'sd0 : r_nrm[r_col];
            2'd1: operand = r_n4[r_col];
            2'd2: operand = (r_col == 2'd3) ? 32'sd0 : r_pos[r_col];
            default: operand = r_e[r_col];
        endcase
    end

    // the fetched coefficient and operand are registered; the product is combinational
    assign prod      = 64'(r_ca) * 64'(r_cb);
    assign acc_sum   = r_acc + 66'(prod >>> FRAC_BITS) + 66'(r_bias);
    assign last_term = (r_phase == 2'd3) && (r_row == 2'd3) && (r_col == 2'd3);

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_vert  = '{x: r_c[0], y: r_c[1], z: r_c[2], w: r_c[3], lt: r_lt,
                       last: (r_vcnt == 2'd0)};

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && i_item.op == OP_LOAD &&
                i_item.coef_index < 6'(COEF_DEPTH)) begin
            r_coef[i_item.coef_index] <= i_item.coef_value;
        end
        if (i_valid && o_ready) begin
            r_pos[0] <= i_item.pos_x;
            r_pos[1] <= i_item.pos_y;
            r_pos[2] <= i_item.pos_z;
            r_nrm[0] <= i_item.norm_x;
            r_nrm[1] <= i_item.norm_y;
            r_nrm[2] <= i_item.norm_z;
        end
        r_ca     <= r_coef[coef_addr];
        r_cb     <= operand;
        // view-model row adds its translation term alone
        r_bias   <= (r_phase == 2'd2 && r_col == 2'd3) ? r_coef[coef_addr] : 32'sd0;
        r_prow   <= r_row;
        r_pphase <= r_phase;
        r_plast  <= (r_col == 2'd3);
        if (r_pv) begin
            if (r_plast) begin
                r_acc <= '0;
                unique case (r_pphase)
                    2'd0: r_n4[r_prow] <= sat32(acc_sum);
                    2'd1: r_lt <= (sat32(acc_sum) < floor_lt) ? floor_lt
                                                              : sat32(acc_sum);
                    2'd2: r_e[r_prow] <= sat32(acc_sum);
                    default: r_c[r_prow] <= sat32(acc_sum);
                endcase
            end else begin
                r_acc <= acc_sum;
            end
        end else begin
            r_acc <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 2'd0;
            r_row   <= 2'd0;
            r_col   <= 2'd0;
            r_vcnt  <= 2'd0;
            r_pv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_pv <= 1'b0;
                    if (i_valid && i_item.op == OP_VERTEX) begin
                        r_state <= S_RUN;
                        r_phase <= 2'd0;
                        r_row   <= 2'd0;
                        r_col   <= 2'd0;
                        r_vcnt  <= (r_vcnt == 2'd2) ? 2'd0 : r_vcnt + 2'd1;
                    end
                end
                S_RUN: begin
                    // one fetch a cycle; a sum lands before the next phase reads it
                    r_pv  <= 1'b1;
                    r_col <= r_col + 2'd1;
                    if (r_col == 2'd3) begin
                        if (r_row == 2'd3 || r_phase == 2'd1) begin
                            r_phase <= r_phase + 2'd1;
                            r_row   <= 2'd0;
                        end else begin
                            r_row <= r_row + 2'd1;
                        end
                    end
                    if (last_term) r_state <= S_TAIL;
                end
                S_TAIL: begin
                    // last projection sum is written here
                    r_pv    <= 1'b0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- design/ttlc_queue.sv -----
// short queue between the front and back parts
// two-entry fifo of transformed vertices; depends on ttlc_pkg

module ttlc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ttlc_pkg::t_vert i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output ttlc_pkg::t_vert o_data
);
    import ttlc_pkg::*;

    t_vert      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// ----- design/ttlc_back.sv -----
// back part: holds a triangle, culls on w, works out facing and the divides
// one shared restoring divider, one quotient bit a cycle; depends on ttlc_pkg

module ttlc_back #(
    parameter int FRAC_BITS = ttlc_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ttlc_pkg::t_vert   i_vert,
    output logic              o_valid,
    input  logic              i_ready,
    output ttlc_pkg::t_result o_res
);
    import ttlc_pkg::*;

    localparam logic [2:0] S_COLLECT = 3'd0;
    localparam logic [2:0] S_CROSS   = 3'd1;
    localparam logic [2:0] S_DIV     = 3'd2;
    localparam logic [2:0] S_EMIT    = 3'd3;
    localparam logic [2:0] S_CROSS2  = 3'd4;
    localparam int DIV_BITS = 32 + FRAC_BITS;
    localparam int SW       = $clog2(DIV_BITS);

    logic [2:0]  r_state;
    logic [1:0]  r_cnt;
    logic [1:0]  r_k;
    logic        r_sel;
    t_vert       r_v [3];
    logic        r_back;
    logic signed [63:0] r_p1;
    logic signed [31:0] r_ndx;
    logic [SW-1:0] r_step;
    logic [DIV_BITS-1:0] r_quo;
    logic [32:0] r_rem;
    logic        r_neg;

    logic signed [31:0] min_w;
    logic signed [31:0] ax, ay, bx, by;
    logic signed [31:0] num;
    logic [31:0]        mag;
    logic [DIV_BITS-1:0] dividend;
    logic [33:0]        trial;
    logic               q_bit;
    logic signed [DIV_BITS:0] sq;
    logic signed [31:0] qsat;
    logic               cull;

    assign min_w = 32'(((64'sd1 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
    assign ax = sat32(66'(r_v[1].x) - 66'(r_v[0].x));
    assign ay = sat32(66'(r_v[1].y) - 66'(r_v[0].y));
    assign bx = sat32(66'(r_v[2].x) - 66'(r_v[0].x));
    assign by = sat32(66'(r_v[2].y) - 66'(r_v[0].y));
    assign cull = (r_v[0].w < min_w) || (r_v[1].w < min_w) || (r_v[2].w < min_w);

    assign num      = r_sel ? r_v[r_k].y : r_v[r_k].x;
    assign mag      = num[31] ? 32'(-num) : num;
    assign dividend = DIV_BITS'(mag) << FRAC_BITS;
    assign trial    = {r_rem, dividend[SW'(DIV_BITS - 1) - r_step]};
    assign q_bit    = (trial >= {2'b0, r_v[r_k].w});
    assign sq       = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign qsat     = sat32(66'(sq));

    assign o_ready = (r_state == S_COLLECT);
    assign o_valid = (r_state == S_EMIT);
    assign o_res   = '{ndc_x: r_ndx, ndc_y: qsat, clip_z: r_v[r_k].z,
                       clip_w: r_v[r_k].w, light_level: r_v[r_k].lt[30:0],
                       back_facing: r_back, last_vertex: (r_k == 2'd2)};

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_v[r_cnt] <= i_vert;
        if (r_state == S_CROSS) r_p1 <= 64'(ax) * 64'(by);
        if (r_state == S_CROSS2) r_back <= (r_p1 - 64'(ay) * 64'(bx)) > 64'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_cnt   <= 2'd0;
            r_k     <= 2'd0;
            r_sel   <= 1'b0;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_COLLECT: begin
                    if (i_valid) begin
                        if (i_vert.last) begin
                            r_cnt   <= 2'd0;
                            r_state <= S_CROSS;
                        end else begin
                            r_cnt <= r_cnt + 2'd1;
                        end
                    end
                end
                S_CROSS: begin
                    r_state <= cull ? S_COLLECT : S_CROSS2;
                end
                S_CROSS2: begin
                    r_state <= S_DIV;
                    r_k     <= 2'd0;
                    r_sel   <= 1'b0;
                    r_step  <= '0;
                    r_rem   <= '0;
                    r_quo   <= '0;
                end
                S_DIV: begin
                    if (r_step == '0) r_neg <= num[31];
                    r_quo <= {r_quo[DIV_BITS-2:0], q_bit};
                    if (r_step == SW'(DIV_BITS - 1)) begin
                        r_step <= '0;
                        r_rem  <= '0;
                        if (!r_sel) begin
                            r_sel <= 1'b1;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_step <= r_step + SW'(1);
                        r_rem  <= q_bit ? 33'(trial - {2'b0, r_v[r_k].w}) : trial[32:0];
                    end
                end
                S_EMIT: begin
                    if (i_ready) begin
                        r_sel  <= 1'b0;
                        r_quo  <= '0;
                        if (r_k == 2'd2) begin
                            r_state <= S_COLLECT;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_DIV;
                        end
                    end
                end
                default: r_state <= S_COLLECT;
            endcase
        end
    end

    // x quotient is parked when the y divide starts
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && !r_sel && r_step == SW'(DIV_BITS - 1)) begin
            r_ndx <= sat32(66'(r_neg ? -$signed({1'b0, r_quo[DIV_BITS-2:0], q_bit})
                                     : $signed({1'b0, r_quo[DIV_BITS-2:0], q_bit})));
        end
    end
endmodule

// ----- design/triangle_transform_light_cull.sv -----
// top level of the triangle transform and light cull block
// joins front, queue and back; depends on ttlc_pkg, ttlc_if and the submodules

// In the front part each vertex walks 52 products one a cycle through the one
// shared 32x32 multiplier; S_TAIL then finishes the last sum, S_OUT hands the
// vertex to the queue once it has room and S_IDLE accepts the next beat; a load
// beat is taken in S_IDLE and leaves the front there. The back part culls and
// works out facing in S_CROSS and S_CROSS2, then divides x and y by w one
// quotient bit a cycle and emits each vertex in S_EMIT, so it sets the pace for
// emitted triangles while the queue lets the front transform the next one.
// Culled triangles give no beats; emitted ones give three, the last flagged.
module triangle_transform_light_cull #(
    parameter int FRAC_BITS = ttlc_pkg::FRAC_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ttlc_if.sink   in_ch,
    ttlc_if.source out_ch
);
    import ttlc_pkg::*;

    logic  f_valid, f_ready, b_valid, b_ready;
    t_vert f_vert, b_vert;

    ttlc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(in_ch.valid), .o_ready(in_ch.ready), .i_item(in_ch.data),
        .o_valid(f_valid), .i_ready(f_ready), .o_vert(f_vert)
    );

    ttlc_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_vert),
        .o_valid(b_valid), .i_ready(b_ready), .o_data(b_vert)
    );

    ttlc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(b_valid), .o_ready(b_ready), .i_vert(b_vert),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_res(out_ch.data)
    );
endmodule
